### rtl/oaat_pkg.sv
// Shared types and constants for the one-at-a-time hash hex unit.
// No dependencies; used by every module of the block.
`default_nettype none

package oaat_pkg;

  localparam int HASH_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int CHAR_W    = 7;
  localparam int NIB_N     = HASH_W / 4;
  localparam int NIB_IDX_W = $clog2(NIB_N);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = HASH_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGN_EXTEND = 1'b1;

  localparam logic [HASH_W-1:0] SEED_RESET = 32'd12;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              byte_present;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] hex_char;
    logic              last_char;
  } out_item_t;

  // one mixed (not yet finalized) hash moving front -> queue -> back
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
  } hash_req_t;

endpackage

`default_nettype wire

### rtl/one_at_a_time_hash_hex_unit.sv
// Top level of the one-at-a-time hash hex unit: config registers, front, queue, back.
// Depends on oaat_pkg, oaat_front, oaat_queue, oaat_back.
//
// Usage:
//  - Byte channel (byte_valid/byte_stall/byte_item): one request per payload
//    byte; last_byte closes the message. An empty request with last_byte set
//    finalizes without a byte; an empty request without it is dropped.
//  - Char channel (char_valid/char_stall/char_item): lowercase hex digits of
//    the finalized hash, most significant first, no leading zeros, last_char
//    on the final digit. A zero hash yields a single "0".
//  - Config port: cfg_we/cfg_index/cfg_data; index 0 = hash_seed (reset 12),
//    index 1 = sign_extend_bytes (reset 1). Write only while idle.
// Throughput: one byte request per cycle; the front mixing step is combinational
//   into the running hash register. Finished messages wait in a two-entry
//   queue, so the byte side stalls only when that queue is full.
// Back end: the avalanche in two steps (ST_IDLE, ST_FIN) and the digit search
//   (ST_TOP) come before the first digit, then one digit per cycle while
//   char_stall is low; a new hash is popped only in ST_IDLE.
// Reset (rst, synchronous): clears queue and state machines, reloads config.
// A stalled digit holds; the front keeps taking bytes until the queue fills.
`default_nettype none

module one_at_a_time_hash_hex_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             byte_valid,
  output logic                                  byte_stall,
  input  wire oaat_pkg::in_item_t               byte_item,
  output logic                                  char_valid,
  input  wire logic                             char_stall,
  output oaat_pkg::out_item_t                   char_item,
  input  wire logic                             cfg_we,
  input  wire logic [oaat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [oaat_pkg::CFG_W-1:0]       cfg_data
);
  import oaat_pkg::*;

  logic [HASH_W-1:0] hash_seed;
  logic              sign_extend_bytes;
  hash_req_t         push;
  hash_req_t         head;
  logic              queue_full;
  logic              pop;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed         <= SEED_RESET;
      sign_extend_bytes <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HASH_SEED:   hash_seed         <= cfg_data;
        REG_SIGN_EXTEND: sign_extend_bytes <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  oaat_front u_front (
    .clk               (clk),
    .rst               (rst),
    .byte_valid        (byte_valid),
    .byte_item         (byte_item),
    .queue_full        (queue_full),
    .hash_seed         (hash_seed),
    .sign_extend_bytes (sign_extend_bytes),
    .byte_stall        (byte_stall),
    .push              (push)
  );

  oaat_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (queue_full)
  );

  oaat_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .char_stall (char_stall),
    .pop        (pop),
    .char_valid (char_valid),
    .char_item  (char_item)
  );

endmodule

`default_nettype wire

### rtl/oaat_front.sv
// Front end: accepts byte requests and runs the per-byte mixing step.
// Depends on oaat_pkg; pushes finished messages into oaat_queue.
`default_nettype none

module oaat_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    byte_valid,
  input  wire oaat_pkg::in_item_t      byte_item,
  input  wire logic                    queue_full,
  input  wire logic [oaat_pkg::HASH_W-1:0] hash_seed,
  input  wire logic                    sign_extend_bytes,
  output logic                         byte_stall,
  output oaat_pkg::hash_req_t          push
);
  import oaat_pkg::*;

  logic              busy;
  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] ext_byte;
  logic [HASH_W-1:0] h_start;
  logic [HASH_W-1:0] h_add;
  logic [HASH_W-1:0] h_shl;
  logic [HASH_W-1:0] h_mix;
  logic              accept;

  assign byte_stall = queue_full;
  assign accept     = byte_valid & ~byte_stall;

  always_comb begin
    if (sign_extend_bytes && byte_item.data_byte[BYTE_W-1]) begin
      ext_byte = {{(HASH_W-BYTE_W){1'b1}}, byte_item.data_byte};
    end else begin
      ext_byte = {{(HASH_W-BYTE_W){1'b0}}, byte_item.data_byte};
    end
    h_start = busy ? running_hash : hash_seed;
    h_add   = h_start + ext_byte;
    h_shl   = h_add + (h_add << 10);
    h_mix   = h_shl ^ (h_shl >> 6);
    push.valid = accept & byte_item.last_byte;
    push.hash  = byte_item.byte_present ? h_mix : h_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && (byte_item.byte_present || byte_item.last_byte)) begin
      if (byte_item.last_byte) begin
        busy <= 1'b0;
      end else begin
        busy         <= 1'b1;
        running_hash <= h_mix;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/oaat_queue.sv
// Two-entry queue of mixed hashes between front and back ends.
// Depends on oaat_pkg.
`default_nettype none

module oaat_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire oaat_pkg::hash_req_t push,
  input  wire logic                pop,
  output oaat_pkg::hash_req_t      head,
  output logic                     full
);
  import oaat_pkg::*;

  logic [HASH_W-1:0] slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              do_pop;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.hash  = slots[rd_ptr];
  assign do_pop     = pop & head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.hash;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push.valid, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/oaat_back.sv
// Back end: final avalanche, leading-digit search and hex character output.
// Depends on oaat_pkg; pops hashes from oaat_queue.
`default_nettype none

module oaat_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire oaat_pkg::hash_req_t head,
  input  wire logic                char_stall,
  output logic                     pop,
  output logic                     char_valid,
  output oaat_pkg::out_item_t      char_item
);
  import oaat_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_FIN, ST_TOP, ST_EMIT} state_t;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A_OFS = 7'h57; // 'a' - 10

  state_t               state;
  logic [HASH_W-1:0]    hash;
  logic [NIB_IDX_W-1:0] nib_idx;
  logic [HASH_W-1:0]    fin_add;
  logic [HASH_W-1:0]    fin_a;
  logic [NIB_IDX_W-1:0] top_nib;
  logic [3:0]           cur_nib;

  // h += h<<3; h ^= h>>11 on the queue head
  always_comb begin
    fin_add = head.hash + (head.hash << 3);
    fin_a   = fin_add ^ (fin_add >> 11);
  end

  // most significant nonzero nibble, zero hash gives nibble 0
  always_comb begin
    top_nib = '0;
    for (int i = 1; i < NIB_N; i++) begin
      if (hash[i*4 +: 4] != 4'd0) begin
        top_nib = NIB_IDX_W'(i);
      end
    end
  end

  always_comb begin
    cur_nib              = hash[{nib_idx, 2'b00} +: 4];
    char_item.hex_char   = (cur_nib < 4'd10) ? ASCII_ZERO + CHAR_W'(cur_nib)
                                             : ASCII_A_OFS + CHAR_W'(cur_nib);
    char_item.last_char  = (nib_idx == '0);
    char_valid           = (state == ST_EMIT);
    pop                  = (state == ST_IDLE) & head.valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (head.valid) begin
            hash  <= fin_a;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          hash  <= hash + (hash << 15);
          state <= ST_TOP;
        end
        ST_TOP: begin
          nib_idx <= top_nib;
          state   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!char_stall) begin
            if (nib_idx == '0) begin
              state <= ST_IDLE;
            end else begin
              nib_idx <= nib_idx - NIB_IDX_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
